// File: rtl/eld_pkg.sv
`default_nettype none
package eld_pkg;

  localparam int NUM_FLOORS = 16;
  localparam int FLOOR_W = 5;
  localparam int TICK_W = 16;

  localparam logic [TICK_W-1:0] DOOR_TICKS_RESET = 16'd3000;
  localparam logic [TICK_W-1:0] ELAPSED_MAX = 16'hFFFF;

  localparam logic [2:0] FUNC_TICK = 3'd0;
  localparam logic [2:0] FUNC_CABIN = 3'd1;
  localparam logic [2:0] FUNC_HALL_UP = 3'd2;
  localparam logic [2:0] FUNC_HALL_DOWN = 3'd3;
  localparam logic [2:0] FUNC_OPEN = 3'd4;
  localparam logic [2:0] FUNC_CLOSE = 3'd5;

  // mode codes double as direction codes for last_dir
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_UP = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;
  localparam logic [1:0] MODE_DOOR = 2'd3;

  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_STOP = 2'd1;
  localparam logic [1:0] MOTOR_UP = 2'd2;
  localparam logic [1:0] MOTOR_DOWN = 2'd3;

  localparam logic [1:0] DOOR_NONE = 2'd0;
  localparam logic [1:0] DOOR_OPEN = 2'd1;
  localparam logic [1:0] DOOR_CLOSE = 2'd2;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [NUM_FLOORS-1:0] floor_map_t;

  typedef struct packed {
    floor_map_t up_calls;
    floor_map_t down_calls;
    floor_t floor_reg;
    floor_t target_reg;
    logic [1:0] mode_reg;
    logic [1:0] last_dir;
    logic [TICK_W-1:0] door_elapsed;
  } ctl_state_t;

  typedef struct packed {
    logic go;
    logic [1:0] motor;
    floor_t target;
    logic [1:0] mode;
    logic [1:0] last_dir;
  } dispatch_t;

  typedef struct packed {
    logic [1:0] mode_now;
    floor_t target_now;
    floor_t floor_now;
    logic [1:0] door_cmd;
    logic [1:0] motor_cmd;
  } result_t;

  function automatic logic floor_ok(floor_t f);
    return (f != '0) && (int'(f) <= NUM_FLOORS);
  endfunction

  function automatic floor_map_t floor_bit(floor_t f);
    floor_map_t m;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      m[i] = ((i + 1) == int'(f));
    end
    return m;
  endfunction

  function automatic floor_map_t above_mask(floor_t f);
    floor_map_t m;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      m[i] = ((i + 1) > int'(f));
    end
    return m;
  endfunction

  function automatic floor_map_t below_mask(floor_t f);
    floor_map_t m;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      m[i] = ((i + 1) < int'(f));
    end
    return m;
  endfunction

  // lowest floor with a call, 0 when none
  function automatic floor_t lowest_floor(floor_map_t m);
    floor_t r;
    r = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (m[i]) r = FLOOR_W'(i + 1);
    end
    return r;
  endfunction

  // highest floor with a call, 0 when none
  function automatic floor_t highest_floor(floor_map_t m);
    floor_t r;
    r = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (m[i]) r = FLOOR_W'(i + 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/eld_dispatch.sv
`default_nettype none
module eld_dispatch (
  input  wire eld_pkg::floor_map_t up_calls,
  input  wire eld_pkg::floor_map_t down_calls,
  input  wire eld_pkg::floor_t     floor_reg,
  input  wire [1:0]                last_dir,
  output eld_pkg::dispatch_t       pick
);

  eld_pkg::floor_t la_up;
  eld_pkg::floor_t hi_down;
  eld_pkg::floor_t hb_down;
  eld_pkg::floor_t lo_up;
  eld_pkg::floor_t up_t;
  eld_pkg::floor_t dn_t;
  logic up_ok;
  logic dn_ok;
  logic any_call;

  // upward sweep: nearest up call above, else highest down call above
  assign la_up = eld_pkg::lowest_floor(up_calls & eld_pkg::above_mask(floor_reg));
  assign hi_down = eld_pkg::highest_floor(down_calls);
  assign up_t = (la_up != '0) ? la_up : ((hi_down > floor_reg) ? hi_down : '0);
  assign up_ok = (up_t != '0);

  // downward sweep: nearest down call below, else lowest up call below
  assign hb_down = eld_pkg::highest_floor(down_calls & eld_pkg::below_mask(floor_reg));
  assign lo_up = eld_pkg::lowest_floor(up_calls);
  assign dn_t = (hb_down != '0) ? hb_down :
                (((lo_up != '0) && (lo_up < floor_reg)) ? lo_up : '0);
  assign dn_ok = (dn_t != '0);

  assign any_call = |(up_calls | down_calls);

  always_comb begin
    pick.go = 1'b0;
    pick.motor = eld_pkg::MOTOR_NONE;
    pick.target = floor_reg;
    pick.mode = eld_pkg::MODE_IDLE;
    pick.last_dir = eld_pkg::MODE_IDLE;
    if (any_call) begin
      if ((last_dir != eld_pkg::MODE_DOWN) && up_ok) begin
        pick.go = 1'b1;
        pick.motor = eld_pkg::MOTOR_UP;
        pick.target = up_t;
        pick.mode = eld_pkg::MODE_UP;
        pick.last_dir = last_dir;
      end else if (dn_ok) begin
        pick.go = 1'b1;
        pick.motor = eld_pkg::MOTOR_DOWN;
        pick.target = dn_t;
        pick.mode = eld_pkg::MODE_DOWN;
        pick.last_dir = eld_pkg::MODE_DOWN;
      end else if (up_ok) begin
        // re-scan upward after turning down found nothing
        pick.go = 1'b1;
        pick.motor = eld_pkg::MOTOR_UP;
        pick.target = up_t;
        pick.mode = eld_pkg::MODE_UP;
        pick.last_dir = eld_pkg::MODE_UP;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/eld_step.sv
`default_nettype none
module eld_step (
  input  wire eld_pkg::ctl_state_t cur,
  input  wire [15:0]               door_open_ticks,
  input  wire [2:0]                func,
  input  wire eld_pkg::floor_t     request_floor,
  input  wire                      floor_reached,
  input  wire eld_pkg::floor_t     sensed_floor,
  output eld_pkg::ctl_state_t      nxt,
  output eld_pkg::result_t         res
);

  eld_pkg::floor_map_t cur_bit;
  eld_pkg::floor_map_t req_bit;
  eld_pkg::floor_map_t sns_bit;
  eld_pkg::floor_map_t up_clr;
  eld_pkg::floor_map_t down_clr;
  eld_pkg::dispatch_t pick;
  logic [1:0] dir_in;
  logic [15:0] elapsed_inc;
  logic req_ok;
  logic sns_ok;
  logic at_target;
  logic same_hit;

  assign cur_bit = eld_pkg::floor_bit(cur.floor_reg);
  assign req_bit = eld_pkg::floor_bit(request_floor);
  assign sns_bit = eld_pkg::floor_bit(sensed_floor);
  assign req_ok = eld_pkg::floor_ok(request_floor);
  assign sns_ok = eld_pkg::floor_ok(sensed_floor);
  assign up_clr = cur.up_calls & ~cur_bit;
  assign down_clr = cur.down_calls & ~cur_bit;
  assign elapsed_inc = (cur.door_elapsed != eld_pkg::ELAPSED_MAX) ?
                       cur.door_elapsed + 16'd1 : cur.door_elapsed;
  assign at_target = (sensed_floor == cur.target_reg);
  assign same_hit = (cur.mode_reg == eld_pkg::MODE_UP) ? |(cur.up_calls & sns_bit) :
                                                        |(cur.down_calls & sns_bit);

  // from rest the search starts with no direction; in the idle case there is
  // no call at the current floor, so the cleared maps equal the stored ones
  assign dir_in = (cur.mode_reg == eld_pkg::MODE_IDLE) ? eld_pkg::MODE_IDLE : cur.last_dir;

  eld_dispatch u_dispatch (
    .up_calls   (up_clr),
    .down_calls (down_clr),
    .floor_reg  (cur.floor_reg),
    .last_dir   (dir_in),
    .pick       (pick)
  );

  always_comb begin
    nxt = cur;
    res.motor_cmd = eld_pkg::MOTOR_NONE;
    res.door_cmd = eld_pkg::DOOR_NONE;
    unique case (func)
      eld_pkg::FUNC_TICK: begin
        unique case (cur.mode_reg)
          eld_pkg::MODE_IDLE: begin
            if (|(cur.up_calls | cur.down_calls)) begin
              if (|((cur.up_calls | cur.down_calls) & cur_bit)) begin
                nxt.up_calls = up_clr;
                nxt.down_calls = down_clr;
                nxt.door_elapsed = '0;
                nxt.mode_reg = eld_pkg::MODE_DOOR;
                res.door_cmd = eld_pkg::DOOR_OPEN;
              end else begin
                nxt.mode_reg = pick.mode;
                nxt.last_dir = pick.last_dir;
                if (pick.go) nxt.target_reg = pick.target;
                res.motor_cmd = pick.motor;
              end
            end
          end
          eld_pkg::MODE_UP, eld_pkg::MODE_DOWN: begin
            if (floor_reached && sns_ok) begin
              nxt.floor_reg = sensed_floor;
              if (same_hit || at_target) begin
                if (cur.mode_reg == eld_pkg::MODE_UP) begin
                  nxt.up_calls = cur.up_calls & ~sns_bit;
                  if (at_target) nxt.down_calls = cur.down_calls & ~sns_bit;
                end else begin
                  nxt.down_calls = cur.down_calls & ~sns_bit;
                  if (at_target) nxt.up_calls = cur.up_calls & ~sns_bit;
                end
                nxt.door_elapsed = '0;
                nxt.last_dir = cur.mode_reg;
                nxt.mode_reg = eld_pkg::MODE_DOOR;
                res.motor_cmd = eld_pkg::MOTOR_STOP;
                res.door_cmd = eld_pkg::DOOR_OPEN;
              end
            end
          end
          default: begin
            nxt.door_elapsed = elapsed_inc;
            if (elapsed_inc >= door_open_ticks) begin
              nxt.up_calls = up_clr;
              nxt.down_calls = down_clr;
              nxt.mode_reg = pick.mode;
              nxt.last_dir = pick.last_dir;
              if (pick.go) nxt.target_reg = pick.target;
              res.motor_cmd = pick.motor;
              res.door_cmd = eld_pkg::DOOR_CLOSE;
            end
          end
        endcase
      end
      eld_pkg::FUNC_CABIN: begin
        if (req_ok) begin
          if (request_floor < cur.floor_reg) nxt.down_calls = cur.down_calls | req_bit;
          else nxt.up_calls = cur.up_calls | req_bit;
        end
      end
      eld_pkg::FUNC_HALL_UP: begin
        if (req_ok) nxt.up_calls = cur.up_calls | req_bit;
      end
      eld_pkg::FUNC_HALL_DOWN: begin
        if (req_ok) nxt.down_calls = cur.down_calls | req_bit;
      end
      eld_pkg::FUNC_OPEN: begin
        if (cur.mode_reg == eld_pkg::MODE_DOOR) nxt.door_elapsed = '0;
      end
      eld_pkg::FUNC_CLOSE: begin
        if (cur.mode_reg == eld_pkg::MODE_DOOR) nxt.door_elapsed = door_open_ticks;
      end
      default: begin
      end
    endcase
    res.floor_now = nxt.floor_reg;
    res.target_now = nxt.target_reg;
    res.mode_now = nxt.mode_reg;
  end

endmodule
`default_nettype wire

// File: rtl/elevator_look_dispatcher.sv
// Elevator controller with a LOOK sweep over up-call and down-call bitmaps.
// Input channel (s_axis): one event item per handshake; tuser carries the
// event kind (tick, cabin request, hall up, hall down, open, close), tdata the
// request floor and, on ticks, the floor sensor reading.
// Output channel (m_axis): exactly one result item per input item, in order:
// motor command, door command, current floor, target floor and mode.
// Configuration: cfg_we writes cfg_wdata into the door-open tick count; write
// it only while no item is in flight.
// Path: an accepted item waits in the input register and moves into the result
// register once that register is empty or its item is being taken; from there it
// is offered on m_axis.
// Throughput: one item per cycle while m_axis_tready stays high; call searches are
// combinational priority encoders between the input register and the result register.
// Reset: calls cleared, car idle at floor 1 with target 1, door count zero,
// door-open tick count 3000, both channels empty.
// Stall: while m_axis_tready is low the result is held; one more item still
// enters the input register, then s_axis_tready drops until the result drains.
`default_nettype none
module elevator_look_dispatcher (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [15:0] s_axis_tdata,  // request_floor[4:0], floor_reached[5], sensed_floor[10:6]
  input  wire [2:0]  s_axis_tuser,  // func[2:0]
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [15:0] m_axis_tdata, // motor_cmd[1:0], door_cmd[3:2], floor_now[8:4],
                                    // target_now[13:9], mode_now[15:14]
  input  wire        cfg_we,
  input  wire [15:0] cfg_wdata
);

  logic in_valid;
  logic [2:0] in_func;
  logic [10:0] in_data;
  logic advance;
  logic [15:0] door_open_ticks;
  eld_pkg::ctl_state_t state;
  eld_pkg::ctl_state_t state_next;
  eld_pkg::result_t res;
  eld_pkg::result_t out_res;

  assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser;
      in_data <= s_axis_tdata[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      door_open_ticks <= eld_pkg::DOOR_TICKS_RESET;
    end else if (cfg_we) begin
      door_open_ticks <= cfg_wdata;
    end
  end

  eld_step u_step (
    .cur             (state),
    .door_open_ticks (door_open_ticks),
    .func            (in_func),
    .request_floor   (in_data[4:0]),
    .floor_reached   (in_data[5]),
    .sensed_floor    (in_data[10:6]),
    .nxt             (state_next),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.up_calls <= '0;
      state.down_calls <= '0;
      state.floor_reg <= eld_pkg::FLOOR_W'(1);
      state.target_reg <= eld_pkg::FLOOR_W'(1);
      state.mode_reg <= eld_pkg::MODE_IDLE;
      state.last_dir <= eld_pkg::MODE_IDLE;
      state.door_elapsed <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = out_res;

`ifndef SYNTH
  a_floor_range: assert property (@(posedge clk) disable iff (rst)
    (state.floor_reg != '0) && (int'(state.floor_reg) <= eld_pkg::NUM_FLOORS))
    else $error("current floor out of range");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    state.last_dir != eld_pkg::MODE_DOOR)
    else $error("last direction holds the door code");

  a_stop_opens: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_res.motor_cmd == eld_pkg::MOTOR_STOP)) |->
      ((out_res.door_cmd == eld_pkg::DOOR_OPEN) && (out_res.mode_now == eld_pkg::MODE_DOOR)))
    else $error("stop without door opening");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_state_moves: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(state))
    else $error("state changed without an item");
`endif

endmodule
`default_nettype wire

// File: tb/sv/elevator_look_dispatcher_checker.sv
`timescale 1ns / 1ps
module elevator_look_dispatcher_checker
  import eld_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [15:0] s_axis_tdata,  // request_floor[4:0], floor_reached[5], sensed_floor[10:6]
  input  wire [2:0]  s_axis_tuser,  // func[2:0]
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [15:0] m_axis_tdata,  // motor_cmd[1:0], door_cmd[3:2], floor_now[8:4],
                                    // target_now[13:9], mode_now[15:14]
  input  wire        cfg_we,
  input  wire [15:0] cfg_wdata,
  output int         outstanding,
  output int         fail_count
);

  // car model
  floor_map_t        up_map;
  floor_map_t        down_map;
  floor_t            car_floor;
  floor_t            car_target;
  logic [1:0]        car_mode;
  logic [1:0]        heading;
  logic [TICK_W-1:0] door_count;
  logic [TICK_W-1:0] door_limit;

  result_t expected_results[$];
  int      errors = 0;

  function automatic floor_map_t floor_mask(floor_t f);
    if (f == '0 || int'(f) > NUM_FLOORS) return '0;
    return floor_map_t'(1) << (f - 1);
  endfunction

  function automatic int first_call_above(floor_map_t m, int f);
    for (int g = f + 1; g <= NUM_FLOORS; g++) begin
      if (m[g-1]) return g;
    end
    return 0;
  endfunction

  function automatic int last_call_below(floor_map_t m, int f);
    int g;
    g = (f > NUM_FLOORS + 1) ? NUM_FLOORS + 1 : f;
    while (g > 1) begin
      if (m[g-2]) return g - 1;
      g--;
    end
    return 0;
  endfunction

  // nearest up call above, else the highest down call if it lies above
  function automatic logic sweep_up();
    int t;
    int h;
    t = first_call_above(up_map, int'(car_floor));
    if (t == 0) begin
      h = last_call_below(down_map, NUM_FLOORS + 1);
      if (h > int'(car_floor)) t = h;
    end
    if (t == 0) return 1'b0;
    car_target = floor_t'(t);
    car_mode = MODE_UP;
    return 1'b1;
  endfunction

  // nearest down call below, else the lowest up call if it lies below
  function automatic logic sweep_down();
    int t;
    int l;
    t = last_call_below(down_map, int'(car_floor));
    if (t == 0) begin
      l = first_call_above(up_map, 0);
      if (l != 0 && l < int'(car_floor)) t = l;
    end
    if (t == 0) return 1'b0;
    car_target = floor_t'(t);
    car_mode = MODE_DOWN;
    return 1'b1;
  endfunction

  function automatic logic [1:0] choose_target();
    if (up_map == '0 && down_map == '0) begin
      car_mode = MODE_IDLE;
      heading = MODE_IDLE;
      return MOTOR_NONE;
    end
    if (heading != MODE_DOWN) begin
      if (sweep_up()) return MOTOR_UP;
      heading = MODE_DOWN;
    end
    if (sweep_down()) return MOTOR_DOWN;
    // one more upward scan, then give up
    heading = MODE_UP;
    if (sweep_up()) return MOTOR_UP;
    car_mode = MODE_IDLE;
    heading = MODE_IDLE;
    return MOTOR_NONE;
  endfunction

  function automatic result_t dispatch_step(logic [2:0] op, floor_t rf, logic hit, floor_t sf);
    result_t    r;
    logic [1:0] motor;
    logic [1:0] door;
    logic       going_up;
    logic       same_hit;
    floor_map_t here;
    motor = MOTOR_NONE;
    door = DOOR_NONE;
    case (op)
      FUNC_TICK: begin
        if (car_mode == MODE_IDLE) begin
          if (up_map != '0 || down_map != '0) begin
            here = floor_mask(car_floor);
            if (((up_map | down_map) & here) != '0) begin
              up_map &= ~here;
              down_map &= ~here;
              door = DOOR_OPEN;
              door_count = '0;
              car_mode = MODE_DOOR;
            end else begin
              heading = MODE_IDLE;
              motor = choose_target();
            end
          end
        end else if (car_mode == MODE_UP || car_mode == MODE_DOWN) begin
          // out-of-range sensor reading counts as no arrival
          if (hit && floor_mask(sf) != '0) begin
            going_up = (car_mode == MODE_UP);
            car_floor = sf;
            here = floor_mask(car_floor);
            same_hit = going_up ? ((up_map & here) != '0) : ((down_map & here) != '0);
            if (same_hit || car_floor == car_target) begin
              motor = MOTOR_STOP;
              if (going_up) begin
                up_map &= ~here;
                if (car_floor == car_target) down_map &= ~here;
              end else begin
                down_map &= ~here;
                if (car_floor == car_target) up_map &= ~here;
              end
              door = DOOR_OPEN;
              door_count = '0;
              heading = going_up ? MODE_UP : MODE_DOWN;
              car_mode = MODE_DOOR;
            end
          end
        end else begin
          if (door_count != ELAPSED_MAX) door_count = door_count + 1'b1;
          if (door_count >= door_limit) begin
            door = DOOR_CLOSE;
            here = floor_mask(car_floor);
            up_map &= ~here;
            down_map &= ~here;
            motor = choose_target();
          end
        end
      end
      FUNC_CABIN: begin
        // at or above the car counts as an up call
        if (floor_mask(rf) != '0) begin
          if (rf < car_floor) down_map |= floor_mask(rf);
          else up_map |= floor_mask(rf);
        end
      end
      FUNC_HALL_UP: up_map |= floor_mask(rf);
      FUNC_HALL_DOWN: down_map |= floor_mask(rf);
      FUNC_OPEN: begin
        if (car_mode == MODE_DOOR) door_count = '0;
      end
      FUNC_CLOSE: begin
        if (car_mode == MODE_DOOR) door_count = door_limit;
      end
      default: ;
    endcase
    r.motor_cmd = motor;
    r.door_cmd = door;
    r.floor_now = car_floor;
    r.target_now = car_target;
    r.mode_now = car_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      up_map = '0;
      down_map = '0;
      car_floor = floor_t'(1);
      car_target = floor_t'(1);
      car_mode = MODE_IDLE;
      heading = MODE_IDLE;
      door_count = '0;
      door_limit = DOOR_TICKS_RESET;
      expected_results.delete();
    end else begin
      // compare before pushing: a result never belongs to an item of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item %h with no expectation pending", m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          got = result_t'(m_axis_tdata);
          check_field("motor_cmd", want.motor_cmd, got.motor_cmd);
          check_field("door_cmd", want.door_cmd, got.door_cmd);
          check_field("floor_now", want.floor_now, got.floor_now);
          check_field("target_now", want.target_now, got.target_now);
          check_field("mode_now", want.mode_now, got.mode_now);
        end
      end
      if (cfg_we) door_limit = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(dispatch_step(s_axis_tuser, s_axis_tdata[4:0],
                                                 s_axis_tdata[5], s_axis_tdata[10:6]));
      end
    end
    outstanding <= expected_results.size();
    fail_count <= errors;
  end

endmodule

// File: tb/sv/elevator_look_dispatcher_tb.sv
`timescale 1ns / 1ps
module elevator_look_dispatcher_tb;
  import eld_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam int PHASE_ITEMS = 96;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  logic idle_on = 1'b1;
  int   hold_ticket = 0;
  int   outstanding;
  int   fail_count;

  elevator_look_dispatcher i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  elevator_look_dispatcher_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on each new ticket
  initial begin
    int hold_left;
    int seen_ticket;
    hold_left = 0;
    seen_ticket = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 14);
      end
    end
  end

  // end the run if nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("elevator_look_dispatcher_tb: FAIL");
    $finish;
  end

  task automatic send_item(input logic [2:0] op, input floor_t rf, input logic hit,
                           input floor_t sf);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 14) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'b0, sf, hit, rf};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold input until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_door_ticks(input logic [15:0] ticks);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic floor_t pick_floor();
    if ($urandom_range(0, 99) < 88) return floor_t'($urandom_range(1, NUM_FLOORS));
    return floor_t'($urandom_range(0, 31));
  endfunction

  task automatic random_event();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 50) op = FUNC_TICK;
    else if (pick < 65) op = FUNC_CABIN;
    else if (pick < 75) op = FUNC_HALL_UP;
    else if (pick < 85) op = FUNC_HALL_DOWN;
    else if (pick < 91) op = FUNC_OPEN;
    else if (pick < 98) op = FUNC_CLOSE;
    else if (pick == 98) op = FUNC_SPARE_LO;
    else op = FUNC_SPARE_HI;
    send_item(op, pick_floor(), $urandom_range(0, 99) < 80, pick_floor());
  endtask

  initial begin
    logic [15:0] phase_ticks[7];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: door only closes via the close button, which also saturates the count
    write_door_ticks(16'hFFFF);
    send_item(FUNC_SPARE_LO, 5'd31, 1'b1, 5'd31);
    send_item(FUNC_SPARE_HI, 5'd0, 1'b0, 5'd0);
    send_item(FUNC_CABIN, 5'd0, 1'b0, 5'd1);
    send_item(FUNC_CABIN, 5'd17, 1'b1, 5'd16);
    send_item(FUNC_HALL_UP, 5'd31, 1'b0, 5'd0);
    send_item(FUNC_OPEN, 5'd1, 1'b0, 5'd1);
    send_item(FUNC_CLOSE, 5'd1, 1'b0, 5'd1);
    send_item(FUNC_CABIN, 5'd1, 1'b0, 5'd1);
    send_item(FUNC_TICK, 5'd0, 1'b0, 5'd1);
    send_item(FUNC_OPEN, 5'd0, 1'b0, 5'd0);
    send_item(FUNC_CLOSE, 5'd0, 1'b0, 5'd0);
    send_item(FUNC_TICK, 5'd0, 1'b0, 5'd1);
    send_item(FUNC_HALL_UP, 5'd16, 1'b0, 5'd0);
    send_item(FUNC_HALL_DOWN, 5'd1, 1'b0, 5'd0);
    send_item(FUNC_HALL_DOWN, 5'd8, 1'b0, 5'd0);
    send_item(FUNC_TICK, 5'd0, 1'b0, 5'd1);
    send_item(FUNC_TICK, 5'd3, 1'b1, 5'd0);
    send_item(FUNC_TICK, 5'd3, 1'b1, 5'd17);
    send_item(FUNC_TICK, 5'd3, 1'b0, 5'd8);
    send_item(FUNC_TICK, 5'd3, 1'b1, 5'd8);
    send_item(FUNC_TICK, 5'd3, 1'b1, 5'd16);
    send_item(FUNC_CLOSE, 5'd0, 1'b0, 5'd0);
    send_item(FUNC_TICK, 5'd0, 1'b0, 5'd16);
    send_item(FUNC_TICK, 5'd0, 1'b1, 5'd8);
    send_item(FUNC_CABIN, 5'd16, 1'b0, 5'd8);

    phase_ticks[0] = 16'd0;
    phase_ticks[1] = 16'd1;
    phase_ticks[2] = 16'd4;
    phase_ticks[3] = DOOR_TICKS_RESET;
    phase_ticks[4] = 16'hFFFF;
    phase_ticks[5] = 16'd2;
    phase_ticks[6] = 16'($urandom_range(0, 8));
    for (int p = 0; p < 7; p++) begin
      write_door_ticks(phase_ticks[p]);
      idle_on <= (p != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the result side while items keep coming, so the input backs up
        if (p == 2 && n == 20) hold_ticket <= hold_ticket + 1;
        random_event();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("elevator_look_dispatcher_tb: PASS");
    end else begin
      $display("elevator_look_dispatcher_tb: FAIL");
    end
    $finish;
  end

endmodule
